@@ sv/rrpc_pkg.sv @@
// Shared constants, types and register indexes for the radial rainbow pixel unit.
// No dependencies.
`default_nettype none
package rrpc_pkg;
    localparam int COORD_BITS = 8;
    localparam int HUE_BITS   = 16;

    localparam int FIELD_W = 8;
    localparam int CW      = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SQ_W    = 2 * CW + 1;
    localparam int FRAC_SH = 16;
    localparam int X_W     = SQ_W + FRAC_SH;
    localparam int RT_W    = (X_W + 1) / 2;
    localparam int X2_W    = 2 * RT_W;
    localparam int REM_W   = RT_W + 3;

    localparam int MD_W    = 17;
    localparam int DR_W    = MD_W + 1;
    localparam int NUM_W   = RT_W + HUE_BITS;

    localparam int STEP_W  = 16;
    localparam int SUM_W   = (HUE_BITS > STEP_W) ? HUE_BITS : STEP_W;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP   = CFG_IDX_W'(3);

    localparam logic [MD_W-1:0]   MD_RESET   = MD_W'(256);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3277);

    typedef struct packed {
        logic                vld;
        logic [HUE_BITS-1:0] ofs;
    } t_tag;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;
endpackage
`default_nettype wire

@@ sv/rrpc_sqrt.sv @@
// Pipelined floor square root, one result bit per stage.
// Depends on rrpc_pkg.
`default_nettype none
module rrpc_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire rrpc_pkg::t_tag            i_tag,
    input  wire logic [rrpc_pkg::SQ_W-1:0] i_sq,
    output rrpc_pkg::t_tag                 o_tag,
    output logic [rrpc_pkg::RT_W-1:0]      o_root
);
    import rrpc_pkg::*;

    t_tag              r_tag [RT_W];
    logic [REM_W-1:0]  r_rem [RT_W];
    logic [RT_W-1:0]   r_q   [RT_W];
    logic [X2_W-1:0]   r_x   [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_stage
        t_tag             a_tag;
        logic [REM_W-1:0] a_rem;
        logic [RT_W-1:0]  a_q;
        logic [X2_W-1:0]  a_x;
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] n_rem;
        logic [RT_W-1:0]  n_q;

        if (k == 0) begin : g_first
            assign a_tag = i_tag;
            assign a_rem = '0;
            assign a_q   = '0;
            assign a_x   = X2_W'({i_sq, {FRAC_SH{1'b0}}});
        end else begin : g_next
            assign a_tag = r_tag[k-1];
            assign a_rem = r_rem[k-1];
            assign a_q   = r_q[k-1];
            assign a_x   = r_x[k-1];
        end

        always_comb begin
            t     = {a_rem[REM_W-3:0], a_x[X2_W-1 -: 2]};
            trial = REM_W'({a_q, 2'b01});
            if (t >= trial) begin
                n_rem = t - trial;
                n_q   = {a_q[RT_W-2:0], 1'b1};
            end else begin
                n_rem = t;
                n_q   = {a_q[RT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k].vld <= 1'b0;
            end else if (i_en) begin
                r_tag[k].vld <= a_tag.vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k].ofs <= a_tag.ofs;
                r_rem[k]     <= n_rem;
                r_q[k]       <= n_q;
                r_x[k]       <= {a_x[X2_W-3:0], 2'b00};
            end
        end
    end

    assign o_tag  = r_tag[RT_W-1];
    assign o_root = r_q[RT_W-1];
endmodule
`default_nettype wire

@@ sv/rrpc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage; keeps the low hue bits.
// Depends on rrpc_pkg.
`default_nettype none
module rrpc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [rrpc_pkg::MD_W-1:0]     i_md,
    input  wire rrpc_pkg::t_tag                i_tag,
    input  wire logic [rrpc_pkg::RT_W-1:0]     i_dist,
    output rrpc_pkg::t_tag                     o_tag,
    output logic [rrpc_pkg::HUE_BITS-1:0]      o_quot
);
    import rrpc_pkg::*;

    t_tag                r_tag [NUM_W];
    logic [DR_W-1:0]     r_rem [NUM_W];
    logic [HUE_BITS-1:0] r_q   [NUM_W];
    logic [NUM_W-1:0]    r_n   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        t_tag                a_tag;
        logic [DR_W-1:0]     a_rem;
        logic [HUE_BITS-1:0] a_q;
        logic [NUM_W-1:0]    a_n;
        logic [DR_W-1:0]     t;
        logic [DR_W-1:0]     n_rem;
        logic [HUE_BITS-1:0] n_q;

        if (k == 0) begin : g_first
            assign a_tag = i_tag;
            assign a_rem = '0;
            assign a_q   = '0;
            assign a_n   = {i_dist, {HUE_BITS{1'b0}}};
        end else begin : g_next
            assign a_tag = r_tag[k-1];
            assign a_rem = r_rem[k-1];
            assign a_q   = r_q[k-1];
            assign a_n   = r_n[k-1];
        end

        always_comb begin
            t = {a_rem[DR_W-2:0], a_n[NUM_W-1]};
            if (t >= {1'b0, i_md}) begin
                n_rem = t - {1'b0, i_md};
                n_q   = HUE_BITS'({a_q, 1'b1});
            end else begin
                n_rem = t;
                n_q   = HUE_BITS'({a_q, 1'b0});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k].vld <= 1'b0;
            end else if (i_en) begin
                r_tag[k].vld <= a_tag.vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k].ofs <= a_tag.ofs;
                r_rem[k]     <= n_rem;
                r_q[k]       <= n_q;
                r_n[k]       <= {a_n[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_tag  = r_tag[NUM_W-1];
    assign o_quot = r_q[NUM_W-1];
endmodule
`default_nettype wire

@@ sv/rrpc_hsv.sv @@
// Three-stage hue offset add and HSV-to-RGB at full saturation and value.
// Depends on rrpc_pkg.
`default_nettype none
module rrpc_hsv (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire rrpc_pkg::t_tag                i_tag,
    input  wire logic [rrpc_pkg::HUE_BITS-1:0] i_frac,
    output logic                               o_vld,
    output rrpc_pkg::t_rgb                     o_rgb
);
    import rrpc_pkg::*;

    localparam logic [2:0] SEC_RED_GUP   = 3'd0;
    localparam logic [2:0] SEC_RDN_GREEN = 3'd1;
    localparam logic [2:0] SEC_GRN_BUP   = 3'd2;
    localparam logic [2:0] SEC_GDN_BLUE  = 3'd3;
    localparam logic [2:0] SEC_RUP_BLUE  = 3'd4;

    localparam logic [HUE_BITS:0] HUE_ONE = {1'b1, {HUE_BITS{1'b0}}};

    logic                r_vld_a, r_vld_b, r_vld_c;
    logic [HUE_BITS-1:0] r_hue;
    logic [2:0]          r_sec;
    logic [HUE_BITS-1:0] r_f;
    t_rgb                r_rgb;

    logic [HUE_BITS+2:0] h6;
    logic [HUE_BITS+7:0] up_p;
    logic [HUE_BITS+8:0] dn_p;
    logic [7:0]          up;
    logic [7:0]          down;
    t_rgb                n_rgb;

    always_comb begin
        h6   = (HUE_BITS+3)'(r_hue) * (HUE_BITS+3)'(6);
        up_p = (HUE_BITS+8)'(r_f) * (HUE_BITS+8)'(255);
        dn_p = (HUE_BITS+9)'(HUE_ONE - (HUE_BITS+1)'(r_f)) * (HUE_BITS+9)'(255);
        up   = up_p[HUE_BITS +: 8];
        down = dn_p[HUE_BITS +: 8];
        case (r_sec)
            SEC_RED_GUP:   n_rgb = '{red: 8'd255, green: up,     blue: 8'd0};
            SEC_RDN_GREEN: n_rgb = '{red: down,   green: 8'd255, blue: 8'd0};
            SEC_GRN_BUP:   n_rgb = '{red: 8'd0,   green: 8'd255, blue: up};
            SEC_GDN_BLUE:  n_rgb = '{red: 8'd0,   green: down,   blue: 8'd255};
            SEC_RUP_BLUE:  n_rgb = '{red: up,     green: 8'd0,   blue: 8'd255};
            default:       n_rgb = '{red: 8'd255, green: 8'd0,   blue: down};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_tag.vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue <= i_frac + i_tag.ofs;
            r_sec <= h6[HUE_BITS +: 3];
            r_f   <= h6[HUE_BITS-1:0];
            r_rgb <= n_rgb;
        end
    end

    assign o_vld = r_vld_c;
    assign o_rgb = r_rgb;
endmodule
`default_nettype wire

@@ sv/radial_rainbow_pixel_color_unit.sv @@
// Radial rainbow pixel color unit: top level with config, entry stages and output skid.
// Pixel words pass entry, root, divider, HSV and output registers; one word per cycle sustained while not stalled.
// Depth is set by the bit-per-stage root (17 stages) and divider (33 stages).
// Advance words update the frame offset at entry and produce no output.
// Synchronous active-low reset clears valids, frame offset and config to defaults.
// Depends on rrpc_pkg, rrpc_sqrt, rrpc_div, rrpc_hsv.
`default_nettype none
module radial_rainbow_pixel_color_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_mode,
    input  wire logic [7:0]                      i_row,
    input  wire logic [7:0]                      i_col,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [7:0]                           o_red,
    output logic [7:0]                           o_green,
    output logic [7:0]                           o_blue,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rrpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rrpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rrpc_pkg::*;

    logic [7:0]          r_ctr_row, r_ctr_col;
    logic [MD_W-1:0]     r_max_dist;
    logic [STEP_W-1:0]   r_hue_step;
    logic [HUE_BITS-1:0] r_frame_ofs;

    logic                en;
    logic                in_acc;
    t_tag                r_t0, r_t1;
    logic [CW-1:0]       r_dr, r_dc;
    logic [SQ_W-1:0]     r_sq;
    logic [CW-1:0]       dr, dc, rw, cl, crw, ccl;

    t_tag                sq_tag, dv_tag;
    logic [RT_W-1:0]     root;
    logic [HUE_BITS-1:0] quot;
    logic                hv_vld;
    t_rgb                hv_rgb;

    logic                r_out_vld, r_skid_vld;
    t_rgb                r_out, r_skid;
    logic [MD_W-1:0]     cfg_md;

    assign en          = !r_skid_vld;
    assign o_stall     = r_skid_vld;
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign cfg_md = (i_cfg_data[MD_W-1:0] == '0) ? MD_W'(1) : i_cfg_data[MD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr_row  <= '0;
            r_ctr_col  <= '0;
            r_max_dist <= MD_RESET;
            r_hue_step <= STEP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_ROW: r_ctr_row  <= i_cfg_data[7:0];
                CFG_CENTER_COL: r_ctr_col  <= i_cfg_data[7:0];
                CFG_MAX_DIST:   r_max_dist <= cfg_md;
                CFG_HUE_STEP:   r_hue_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_ofs <= '0;
        end else if (in_acc && i_mode) begin
            r_frame_ofs <= HUE_BITS'(SUM_W'(r_frame_ofs) + SUM_W'(r_hue_step));
        end
    end

    always_comb begin
        rw  = i_row[CW-1:0];
        cl  = i_col[CW-1:0];
        crw = r_ctr_row[CW-1:0];
        ccl = r_ctr_col[CW-1:0];
        dr  = (rw >= crw) ? rw - crw : crw - rw;
        dc  = (cl >= ccl) ? cl - ccl : ccl - cl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0.vld <= 1'b0;
            r_t1.vld <= 1'b0;
        end else if (en) begin
            r_t0.vld <= in_acc && !i_mode;
            r_t1.vld <= r_t0.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t0.ofs <= r_frame_ofs;
            r_dr     <= dr;
            r_dc     <= dc;
            r_t1.ofs <= r_t0.ofs;
            r_sq     <= SQ_W'(r_dr) * SQ_W'(r_dr) + SQ_W'(r_dc) * SQ_W'(r_dc);
        end
    end

    rrpc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (r_t1),
        .i_sq    (r_sq),
        .o_tag   (sq_tag),
        .o_root  (root)
    );

    rrpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_md    (r_max_dist),
        .i_tag   (sq_tag),
        .i_dist  (root),
        .o_tag   (dv_tag),
        .o_quot  (quot)
    );

    rrpc_hsv u_hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (dv_tag),
        .i_frac  (quot),
        .o_vld   (hv_vld),
        .o_rgb   (hv_rgb)
    );

    // output word plus one skid word; pipeline halts only while skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (en) begin
            if (!r_out_vld || !i_stall) begin
                r_out_vld <= hv_vld;
            end else if (hv_vld) begin
                r_skid_vld <= 1'b1;
            end
        end else if (!i_stall) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_out_vld || !i_stall) begin
                r_out <= hv_rgb;
            end else begin
                r_skid <= hv_rgb;
            end
        end else if (!i_stall) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_out.red;
    assign o_green = r_out.green;
    assign o_blue  = r_out.blue;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held without output word");

    a_advance_ofs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode) |=>
        (r_frame_ofs == HUE_BITS'(SUM_W'($past(r_frame_ofs)) + SUM_W'($past(r_hue_step)))))
        else $error("frame offset not advanced by hue step");

    a_advance_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode) |=> !r_t0.vld)
        else $error("advance word entered pipeline");

    a_hold_ofs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && i_mode) |=> $stable(r_frame_ofs))
        else $error("frame offset changed without advance");
endmodule
`default_nettype wire

@@ test/tb_radial_rainbow_pixel_color_unit.sv @@
// Testbench for radial_rainbow_pixel_color_unit: drives pixel and advance words and
// register writes, predicts each pixel color in a scoreboard class and checks outputs.
// Depends on rrpc_pkg and the unit RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_radial_rainbow_pixel_color_unit;
    import rrpc_pkg::*;

    localparam int LATENCY = 56;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    class color_board;
        bit [7:0]  ctr_row;
        bit [7:0]  ctr_col;
        bit [16:0] max_dist;
        bit [15:0] step;
        bit [15:0] frame_ofs;
        t_color    pending[$];
        int        errors;

        function void reset_regs();
            ctr_row = 0;
            ctr_col = 0;
            max_dist = 17'd256;
            step = 16'd3277;
            frame_ofs = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_CENTER_ROW: ctr_row = data[7:0];
                CFG_CENTER_COL: ctr_col = data[7:0];
                CFG_MAX_DIST:   max_dist = data[16:0];
                CFG_HUE_STEP:   step = data[15:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] isqrt(bit [63:0] x);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            for (int k = 0; k < 32; k++) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void note_word(bit mode, bit [7:0] row, bit [7:0] col);
            bit [63:0] dr, dc, rad, md, hue, h6, f, up, down;
            t_color c;
            if (mode) begin
                frame_ofs = frame_ofs + step;
                return;
            end
            dr = row >= ctr_row ? row - ctr_row : ctr_row - row;
            dc = col >= ctr_col ? col - ctr_col : ctr_col - col;
            rad = isqrt((dr * dr + dc * dc) << 16);
            md = max_dist == 0 ? 64'd1 : 64'(max_dist);
            hue = (((rad << 16) / md) + frame_ofs) & 64'hFFFF;
            h6 = hue * 6;
            f = h6 & 64'hFFFF;
            up = (f * 255) >> 16;
            down = ((64'h10000 - f) * 255) >> 16;
            case (h6 >> 16)
                0: c = '{8'd255, up[7:0], 8'd0};
                1: c = '{down[7:0], 8'd255, 8'd0};
                2: c = '{8'd0, 8'd255, up[7:0]};
                3: c = '{8'd0, down[7:0], 8'd255};
                4: c = '{up[7:0], 8'd0, 8'd255};
                default: c = '{8'd255, 8'd0, down[7:0]};
            endcase
            pending.push_back(c);
        endfunction

        function void check_word(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            t_color e;
            if (pending.size() == 0) begin
                $error("unexpected output word r=%0d g=%0d b=%0d", r, g, b);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r !== e.red) begin
                $error("red: expected %0d, got %0d", e.red, r);
                errors++;
            end
            if (g !== e.green) begin
                $error("green: expected %0d, got %0d", e.green, g);
                errors++;
            end
            if (b !== e.blue) begin
                $error("blue: expected %0d, got %0d", e.blue, b);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_stall;
    logic                  in_mode = 0;
    logic [7:0]            in_row = 0;
    logic [7:0]            in_col = 0;
    logic                  out_valid;
    logic                  out_stall = 0;
    logic [7:0]            out_red, out_green, out_blue;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = 0;
    logic [CFG_DATA_W-1:0] cfg_data = 0;

    color_board board = new();
    int  hold_off = 0;
    bit  stalls_on = 1;

    radial_rainbow_pixel_color_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_mode(in_mode), .i_row(in_row), .i_col(in_col),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_red(out_red), .o_green(out_green), .o_blue(out_blue),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stall per word, plus a long hold-off on request
    initial begin
        int gap;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                board.check_word(out_red, out_green, out_blue);
            end
            if (hold_off > 0) begin
                out_stall <= 1;
                hold_off = hold_off - 1;
            end else if (out_valid && !out_stall) begin
                gap = stalls_on ? $urandom_range(0, 7) : 0;
                out_stall <= (gap != 0);
                for (int k = 1; k < gap; k++) @(posedge clk);
                if (gap != 0) begin
                    @(posedge clk);
                    out_stall <= 0;
                end
            end else begin
                out_stall <= 0;
            end
        end
    end

    task automatic send_word(bit mode, bit [7:0] row, bit [7:0] col, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (in_valid && gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end else if (gap != 0) begin
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_mode <= mode;
        in_row <= row;
        in_col <= col;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_word(mode, row, col);
    endtask

    task automatic finish_words();
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic random_words(int n, int adv_pct);
        for (int k = 0; k < n; k++)
            send_word($urandom_range(0, 99) < adv_pct, 8'($urandom), 8'($urandom),
                      (k % 200) < 150);
        finish_words();
    endtask

    initial begin
        logic [16:0] mds[5];
        board.reset_regs();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, both modes, reset registers
        send_word(0, 0, 0, 0);
        send_word(0, 255, 255, 0);
        send_word(0, 255, 0, 0);
        send_word(0, 0, 255, 0);
        send_word(0, 16, 0, 0);
        send_word(1, 8'hAA, 8'h55, 0);
        send_word(0, 3, 4, 0);
        send_word(1, 255, 255, 0);
        send_word(0, 100, 200, 0);
        finish_words();
        drain();

        // zero max distance counts as one; unknown index ignored
        write_reg(CFG_MAX_DIST, 32'h0);
        write_reg(CFG_HUE_STEP, 32'hFFFF);
        write_reg(4'd9, 32'hFFFF_FFFF);
        send_word(0, 0, 0, 0);
        send_word(0, 1, 0, 0);
        send_word(0, 200, 31, 0);
        send_word(1, 0, 0, 0);
        send_word(0, 7, 9, 0);
        finish_words();
        drain();

        // centre at the far corner, smallest and largest distances
        write_reg(CFG_CENTER_ROW, 32'hFFFF_FFFF);
        write_reg(CFG_CENTER_COL, 32'h0000_01FF);
        write_reg(CFG_MAX_DIST, 32'd92682);
        write_reg(CFG_HUE_STEP, 32'h0);
        send_word(0, 0, 0, 0);
        send_word(0, 255, 255, 0);
        send_word(1, 0, 0, 0);
        send_word(0, 128, 64, 0);
        finish_words();

        // long receiver hold-off while words keep coming
        hold_off = 300;
        random_words(150, 10);
        drain();

        mds[0] = 17'd1; mds[1] = 17'd256; mds[2] = 17'd92682;
        mds[3] = 17'h1FFFF; mds[4] = 17'd5000;
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_CENTER_ROW, $urandom);
            write_reg(CFG_CENTER_COL, $urandom);
            write_reg(CFG_MAX_DIST, p == 4 ? $urandom_range(1, 92682) : mds[p]);
            write_reg(CFG_HUE_STEP, $urandom);
            stalls_on = (p != 2);
            random_words(370, 15);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
